// ===== rtl/cp2u8_pkg.sv =====
// Package with the field widths, item kind codes and the UTF-8 encoding function.
package cp2u8_pkg;

   localparam int CP_WIDTH    = 21;
   localparam int BYTE_WIDTH  = 8;
   localparam int KIND_WIDTH  = 2;
   localparam int TABLE_DEPTH = 128;
   localparam int INDEX_WIDTH = 7;

   localparam logic [KIND_WIDTH-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_BYTE   = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ENCODE = 2'd2;

   localparam logic [CP_WIDTH-1:0] LIMIT_ONE   = 21'd128;
   localparam logic [CP_WIDTH-1:0] LIMIT_TWO   = 21'd2048;
   localparam logic [CP_WIDTH-1:0] LIMIT_THREE = 21'd65536;
   localparam logic [CP_WIDTH-1:0] LIMIT_FOUR  = 21'd1114112;

   typedef logic [CP_WIDTH-1:0]   code_type;
   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [KIND_WIDTH-1:0] kind_type;

   typedef struct packed {
      logic [2:0]          count;
      logic [3:0][7:0]     bytes;
   } utf8_type;

   function automatic utf8_type utf8_encode(input code_type cp);
      utf8_type r;
      r.count = 3'd0;
      r.bytes = '0;
      if (cp < LIMIT_ONE) begin
         r.count    = 3'd1;
         r.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp < LIMIT_TWO) begin
         r.count    = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < LIMIT_THREE) begin
         r.count    = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else if (cp < LIMIT_FOUR) begin
         r.count    = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/cp2u8_req_if.sv =====
// Request channel interface carrying one input transaction.
interface cp2u8_req_if;
   import cp2u8_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type byte_value;
   code_type code_point;

   modport source (output valid, output kind, output byte_value, output code_point,
                   input ready);
   modport sink   (input valid, input kind, input byte_value, input code_point,
                   output ready);
endinterface

// ===== rtl/cp2u8_rsp_if.sv =====
// Response channel interface carrying one UTF-8 byte per transaction.
interface cp2u8_rsp_if;
   import cp2u8_pkg::*;

   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== rtl/cp2u8_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cp2u8_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/codepage_to_utf8_transcoder.sv =====
// Top level of the code page to UTF-8 transcoder.
//
//   channel   direction  transaction
//   req_chan  in         kind, byte_value, code_point
//   rsp_chan  out        out_byte, last_byte (one UTF-8 byte)
//
// A request is taken in every cycle while the lookup stage can move on; it reads the
// table RAM, and from the lookup stage it is encoded into 1 to 4 bytes held in the output
// register, or into none for a code point from 1114112 up. The output register sends one
// byte per cycle while the response side is ready. Reset clears the valid bits and the
// last mapped code point at once; the table contents stay undefined until loaded. A
// stalled response holds the lookup stage and the request side.
module codepage_to_utf8_transcoder (
   input logic        clock,
   input logic        reset,
   cp2u8_req_if.sink   req_chan,
   cp2u8_rsp_if.source rsp_chan
);
   import cp2u8_pkg::*;

   logic                   req_fire;
   logic                   rsp_fire;
   logic                   load_write;
   logic                   s1_enter;
   logic [INDEX_WIDTH-1:0] req_index;
   code_type               ram_rd_data;

   logic [TABLE_DEPTH-1:0] map_valid_ff, map_valid_in;
   code_type               last_code_ff, last_code_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_encode_ff;
   byte_type               s1_byte_ff;
   code_type               s1_cp_ff;
   logic                   s1_hit_ff;

   logic                   ser_valid_ff, ser_valid_in;
   logic [3:0][7:0]        ser_bytes_ff, ser_bytes_in;
   logic [1:0]             ser_left_ff, ser_left_in;

   code_type               cp_sel;
   utf8_type               enc;
   logic                   ser_free;
   logic                   s1_advance;

   assign req_index = req_chan.byte_value[INDEX_WIDTH-1:0];
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign load_write = req_fire && (req_chan.kind == KIND_LOAD) && req_chan.byte_value[7];
   assign s1_enter  = req_fire &&
                      ((req_chan.kind == KIND_BYTE) || (req_chan.kind == KIND_ENCODE));

   cp2u8_ram #(.WIDTH(CP_WIDTH), .DEPTH(TABLE_DEPTH)) u_map_ram (
      .clock   (clock),
      .wr_en   (load_write),
      .wr_addr (req_index),
      .wr_data (req_chan.code_point),
      .rd_en   (s1_enter),
      .rd_addr (req_index),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (s1_encode_ff) begin
         cp_sel = s1_cp_ff;
      end else if (!s1_byte_ff[7]) begin
         cp_sel = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, s1_byte_ff};
      end else if (s1_hit_ff) begin
         cp_sel = ram_rd_data;
      end else begin
         cp_sel = last_code_ff;
      end
   end

   assign enc        = utf8_encode(cp_sel);
   assign ser_free   = !ser_valid_ff || (rsp_fire && (ser_left_ff == 2'd0));
   assign s1_advance = s1_valid_ff && ((enc.count == 3'd0) || ser_free);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   always_comb begin
      map_valid_in = map_valid_ff;
      if (load_write) begin
         map_valid_in[req_index] = 1'b1;
      end
      last_code_in = last_code_ff;
      if (s1_advance && !s1_encode_ff && s1_byte_ff[7] && s1_hit_ff) begin
         last_code_in = ram_rd_data;
      end
      s1_valid_in = s1_enter || (s1_valid_ff && !s1_advance);
   end

   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_bytes_in = ser_bytes_ff;
      ser_left_in  = ser_left_ff;
      if (s1_advance && (enc.count != 3'd0)) begin
         ser_valid_in = 1'b1;
         ser_bytes_in = enc.bytes;
         ser_left_in  = 2'(enc.count - 3'd1);
      end else if (rsp_fire) begin
         if (ser_left_ff == 2'd0) begin
            ser_valid_in = 1'b0;
         end else begin
            ser_bytes_in = {8'h00, ser_bytes_ff[3:1]};
            ser_left_in  = ser_left_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
         last_code_ff <= '0;
         s1_valid_ff  <= 1'b0;
         ser_valid_ff <= 1'b0;
      end else begin
         map_valid_ff <= map_valid_in;
         last_code_ff <= last_code_in;
         s1_valid_ff  <= s1_valid_in;
         ser_valid_ff <= ser_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_enter) begin
         s1_encode_ff <= (req_chan.kind == KIND_ENCODE);
         s1_byte_ff   <= req_chan.byte_value;
         s1_cp_ff     <= req_chan.code_point;
         s1_hit_ff    <= map_valid_ff[req_index];
      end
      ser_bytes_ff <= ser_bytes_in;
      ser_left_ff  <= ser_left_in;
   end

   assign rsp_chan.valid     = ser_valid_ff;
   assign rsp_chan.out_byte  = ser_bytes_ff[0];
   assign rsp_chan.last_byte = (ser_left_ff == 2'd0);
endmodule

// ===== rtl/cp2u8_checker.sv =====
// Port-level checker for the transcoder and its bind to the top level.
module cp2u8_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       last_byte
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last_byte))
      else $error("Stalled response transaction changed.");

   a_continuation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_byte |=> rsp_valid && (out_byte[7:6] == 2'b10))
      else $error("Character not followed by a continuation byte.");

   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_byte[7:6] == 2'b11) |-> !last_byte)
      else $error("Lead byte marked as last.");
endmodule

bind codepage_to_utf8_transcoder cp2u8_checker u_cp2u8_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_byte  (rsp_chan.out_byte),
   .last_byte (rsp_chan.last_byte)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the code page to UTF-8 transcoder.
module tb_top;
   import cp2u8_pkg::*;

   localparam kind_type KIND_UNUSED = 2'd3;

   typedef struct {
      kind_type kind;
      byte_type byte_value;
      code_type code_point;
   } source_item_type;

   typedef struct {
      byte_type value;
      logic     is_last;
   } utf8_unit_type;

   logic clock;
   logic reset;
   logic rsp_hold = 1'b0;

   cp2u8_req_if req_chan ();
   cp2u8_rsp_if rsp_chan ();

   codepage_to_utf8_transcoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   source_item_type source_items[$];
   utf8_unit_type   utf8_due[$];

   code_type     cp_table[TABLE_DEPTH];
   logic         cp_loaded[TABLE_DEPTH];
   code_type     recent_code;

   source_item_type current_item;
   logic         offering;
   int           gap_left;
   int           stall_left;
   int           accepted_count;
   int           checked_count;
   int           item_total;
   int           mismatch_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic append_unit(input byte_type value, input logic is_last);
      utf8_unit_type unit;
      unit.value   = value;
      unit.is_last = is_last;
      utf8_due.insert(utf8_due.size(), unit);
   endtask

   task automatic queue_utf8(input code_type cp);
      int          count;
      logic [31:0] wide;
      byte_type    lead;
      byte_type    next_value;
      wide = 32'(cp);
      if (cp < LIMIT_ONE) count = 1;
      else if (cp < LIMIT_TWO) count = 2;
      else if (cp < LIMIT_THREE) count = 3;
      else if (cp < LIMIT_FOUR) count = 4;
      else count = 0;
      case (count)
         1: lead = 8'h00;
         2: lead = 8'hC0;
         3: lead = 8'hE0;
         default: lead = 8'hF0;
      endcase
      for (int k = 0; k < count; k++) begin
         if (k == 0) next_value = lead | 8'(wide >> (6 * (count - 1)));
         else next_value = 8'h80 | 8'((wide >> (6 * (count - 1 - k))) & 32'h3F);
         append_unit(next_value, (k == count - 1));
      end
   endtask

   task automatic transcode_item(input source_item_type item);
      logic [INDEX_WIDTH-1:0] idx;
      idx = item.byte_value[INDEX_WIDTH-1:0];
      if (item.kind == KIND_LOAD) begin
         if (item.byte_value[7]) begin
            cp_table[idx]  = item.code_point;
            cp_loaded[idx] = 1'b1;
         end
      end else if (item.kind == KIND_BYTE) begin
         if (!item.byte_value[7]) begin
            append_unit(item.byte_value, 1'b1);
         end else begin
            if (cp_loaded[idx]) recent_code = cp_table[idx];
            queue_utf8(recent_code);
         end
      end else if (item.kind == KIND_ENCODE) begin
         queue_utf8(item.code_point);
      end
   endtask

   function automatic code_type random_code();
      case ($urandom_range(0, 5))
         0: return code_type'($urandom_range(0, 127));
         1: return code_type'($urandom_range(128, 2047));
         2: return code_type'($urandom_range(2048, 65535));
         3: return code_type'($urandom_range(65536, 1114111));
         4: return code_type'($urandom_range(1114112, 2097151));
         default: return code_type'($urandom_range(0, 2097151));
      endcase
   endfunction

   task automatic add_item(input kind_type kind, input byte_type byte_value,
                           input code_type code_point);
      source_item_type entry;
      entry.kind       = kind;
      entry.byte_value = byte_value;
      entry.code_point = code_point;
      source_items.insert(source_items.size(), entry);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            transcode_item(current_item);
            accepted_count++;
            offering = 1'b0;
            if ((accepted_count % 64) < 20) gap_left = 0;
            else gap_left = $urandom_range(0, 1) ? $urandom_range(0, 17) : 0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (source_items.size() > 0) begin
               current_item = source_items.pop_front();
               offering = 1'b1;
            end
         end
         req_chan.valid      <= offering;
         req_chan.kind       <= current_item.kind;
         req_chan.byte_value <= current_item.byte_value;
         req_chan.code_point <= current_item.code_point;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (utf8_due.size() == 0) begin
               $display("%0t: expected no transaction, got out_byte %02h last_byte %0b",
                        $time, rsp_chan.out_byte, rsp_chan.last_byte);
               mismatch_count++;
            end else begin
               utf8_unit_type want;
               want = utf8_due.pop_front();
               if (rsp_chan.out_byte !== want.value) begin
                  $display("%0t: out_byte expected %02h, got %02h",
                           $time, want.value, rsp_chan.out_byte);
                  mismatch_count++;
               end
               if (rsp_chan.last_byte !== want.is_last) begin
                  $display("%0t: last_byte expected %0b, got %0b",
                           $time, want.is_last, rsp_chan.last_byte);
                  mismatch_count++;
               end
            end
            checked_count++;
            if ((checked_count % 80) < 24) stall_left = 0;
            else stall_left = $urandom_range(0, 1) ? $urandom_range(0, 17) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !rsp_hold;
         end
      end
   end

   // Holds the response side off long enough for the block to back up into the request side.
   initial begin
      wait (accepted_count >= 40);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      source_item_type item;
      int           sel;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.kind       = KIND_LOAD;
      req_chan.byte_value = '0;
      req_chan.code_point = '0;
      rsp_chan.ready      = 1'b0;
      offering            = 1'b0;
      gap_left            = 0;
      stall_left          = 0;
      accepted_count      = 0;
      checked_count       = 0;
      mismatch_count      = 0;
      recent_code         = '0;
      current_item        = '{kind: KIND_LOAD, byte_value: '0, code_point: '0};
      for (int i = 0; i < TABLE_DEPTH; i++) cp_loaded[i] = 1'b0;

      add_item(KIND_ENCODE, 8'h00, 21'h000000);
      add_item(KIND_ENCODE, 8'hFF, 21'h00007F);
      add_item(KIND_ENCODE, 8'h00, 21'h000080);
      add_item(KIND_ENCODE, 8'h00, 21'h0007FF);
      add_item(KIND_ENCODE, 8'h00, 21'h000800);
      add_item(KIND_ENCODE, 8'h00, 21'h00FFFF);
      add_item(KIND_ENCODE, 8'h00, 21'h010000);
      add_item(KIND_ENCODE, 8'h00, 21'h10FFFF);
      add_item(KIND_ENCODE, 8'h00, 21'h110000);
      add_item(KIND_ENCODE, 8'h00, 21'h1FFFFF);
      add_item(KIND_BYTE,   8'h00, 21'h1FFFFF);
      add_item(KIND_BYTE,   8'h7F, 21'h000000);
      // An unloaded entry before any lookup falls back to code point zero.
      add_item(KIND_BYTE,   8'h80, 21'h000000);
      add_item(KIND_LOAD,   8'h80, 21'h0020AC);
      add_item(KIND_BYTE,   8'h80, 21'h000000);
      add_item(KIND_BYTE,   8'hFF, 21'h000000);
      add_item(KIND_LOAD,   8'h41, 21'h001234);
      add_item(KIND_BYTE,   8'h41, 21'h000000);
      add_item(KIND_UNUSED, 8'hFF, 21'h1FFFFF);
      add_item(KIND_LOAD,   8'hFF, 21'h01F600);
      add_item(KIND_BYTE,   8'hFF, 21'h000000);
      add_item(KIND_ENCODE, 8'h00, 21'h000041);
      add_item(KIND_BYTE,   8'h90, 21'h000000);
      add_item(KIND_LOAD,   8'h81, 21'h110000);
      add_item(KIND_BYTE,   8'h81, 21'h000000);
      add_item(KIND_BYTE,   8'h82, 21'h000000);

      for (int n = 0; n < 204; n++) begin
         sel             = $urandom_range(0, 19);
         item.code_point = random_code();
         item.byte_value = byte_type'($urandom_range(0, 255));
         if (sel < 3) begin
            item.kind = KIND_LOAD;
            if (sel != 0) item.byte_value = byte_type'(128 + $urandom_range(0, 39));
         end else if (sel < 13) begin
            item.kind = KIND_BYTE;
            if (sel < 8) item.byte_value = byte_type'(128 + $urandom_range(0, 47));
         end else if (sel < 19) begin
            item.kind = KIND_ENCODE;
         end else begin
            item.kind = KIND_UNUSED;
         end
         source_items.insert(source_items.size(), item);
      end
      item_total = source_items.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == item_total);
      wait (utf8_due.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
